// ----- src/sprite_line_evaluator_assert.svh -----
// assertion helpers for the sprite line evaluator checker
`ifndef SPRITE_LINE_EVALUATOR_ASSERT_SVH
`define SPRITE_LINE_EVALUATOR_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define SLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define SLE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sle_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

    localparam int OAM_BYTES = 256;
    localparam int OAM_AW    = 8;

    localparam int DEF_SPRITE_ENTRIES = 64;
    localparam int DEF_MAX_PER_LINE   = 8;
    localparam int DEF_VISIBLE_LINES  = 240;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    localparam logic [0:0] CFG_SIZE16     = 1'b0;
    localparam logic [0:0] CFG_TABLE_HIGH = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] oam_index;
        logic [7:0] oam_data;
        logic [7:0] target_line;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  slot;
        logic        found;
        logic [12:0] pattern_addr;
        logic [7:0]  attributes;
        logic [7:0]  x_position;
        logic        is_sprite_zero;
        logic        overflow;
        logic        last;
    } t_out_res;

endpackage

`default_nettype wire

// ----- src/sle_oam.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sle_oam
    import sle_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_we,
    input  wire logic [OAM_AW-1:0] i_waddr,
    input  wire logic [7:0]        i_wdata,
    input  wire logic [OAM_AW-1:0] i_raddr,
    output logic      [7:0]        o_rdata
);

    logic [7:0]           r_mem [OAM_BYTES];
    logic [OAM_BYTES-1:0] r_valid;
    logic [7:0]           r_rdata;

    // unwritten bytes read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : 8'd0;
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/sprite_line_evaluator.sv -----
// Sprite line evaluator.
// Input channel (i_in_valid / o_in_ready, payload i_in): a write request stores
// one sprite memory byte; an evaluate request scans the sprite entries for the
// target line and reads the further bytes of each kept sprite, all through the
// single memory read port, which fetches one byte per cycle. o_in_ready is low
// until the last result of an evaluation is loaded into the output register.
// Output channel (o_out_valid / i_out_ready, payload o_out): one result per kept
// sprite, one per cycle while the receiver is ready, the final one marked last; an evaluation with no
// sprite gives one empty result with last set. A stalled receiver holds the
// output register and the result sequencer waits; a new request can be taken
// while the final result still waits.
// Configuration (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data): always
// ready; write only while no request is in progress.
// Reset (i_rst_n low, synchronous) clears the sequencer, the output valid,
// the configuration and the sprite memory contents (to zero).
`timescale 1ns / 1ps
`default_nettype none

module sprite_line_evaluator
    import sle_pkg::*;
#(
    parameter int SPRITE_ENTRIES = DEF_SPRITE_ENTRIES,
    parameter int MAX_PER_LINE   = DEF_MAX_PER_LINE,
    parameter int VISIBLE_LINES  = DEF_VISIBLE_LINES
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_req    i_in,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_res        o_out,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [0:0] i_cfg_index,
    input  wire logic       i_cfg_data
);

    localparam int NW = $clog2(SPRITE_ENTRIES + 1);
    localparam int CW = $clog2(MAX_PER_LINE + 1);
    localparam int BW = (MAX_PER_LINE > 1) ? $clog2(MAX_PER_LINE) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TILE,
        S_ATTR,
        S_XPOS,
        S_STORE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [12:0] pattern_addr;
        logic [7:0]  attributes;
        logic [7:0]  x_position;
        logic        is_sprite_zero;
    } t_kept;

    function automatic logic [OAM_AW-1:0] f_byte_addr(logic [NW-1:0] n, logic [1:0] off);
        logic [NW+9:0] full;
        full = {8'd0, n, 2'b00};
        return {full[OAM_AW-1:2], off};
    endfunction

    function automatic logic [12:0] f_pattern(logic [7:0] tile, logic [7:0] attr,
                                              logic [3:0] row_in, logic size16,
                                              logic thigh);
        logic [3:0] row;
        row = row_in;
        if (attr[7]) begin
            row = size16 ? ~row_in : {1'b0, ~row_in[2:0]};
        end
        if (size16) begin
            return {tile[0], tile[7:1], row[3], 1'b0, row[2:0]};
        end
        return {thigh, tile, 1'b0, row[2:0]};
    endfunction

    t_state          r_state, n_state;
    logic            r_size16, n_size16;
    logic            r_thigh, n_thigh;
    logic [7:0]      r_line, n_line;
    logic [NW-1:0]   r_n, n_n;
    logic            r_pend, n_pend;
    logic [NW-1:0]   r_pend_n, n_pend_n;
    logic [NW-1:0]   r_ent, n_ent;
    logic [3:0]      r_row, n_row;
    logic [7:0]      r_tile, n_tile;
    logic [7:0]      r_attr, n_attr;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_e, n_e;
    logic            r_over, n_over;
    logic            r_out_valid, n_out_valid;
    t_out_res        r_out, n_out;
    t_kept           r_buf [MAX_PER_LINE];

    logic            buf_we;
    t_kept           buf_wdata;
    logic            mem_we;
    logic [OAM_AW-1:0] rd_addr;
    logic [7:0]      rd_data;
    logic            in_acc;
    logic            out_free;
    logic [8:0]      diff;
    logic            hit;
    logic [4:0]      height;
    logic            is_last;
    logic [CW+2:0]   slot_ext;
    t_kept           emit_ent;

    sle_oam u_oam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (i_in.oam_index),
        .i_wdata (i_in.oam_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign in_acc   = i_in_valid && o_in_ready;
    assign mem_we   = in_acc && (i_in.req_type == REQ_WRITE);
    assign out_free = !r_out_valid || i_out_ready;
    assign height   = r_size16 ? 5'd16 : 5'd8;
    assign diff     = {1'b0, r_line} - {1'b0, rd_data};
    assign hit      = !diff[8] && ({1'b0, diff[7:0]} < {4'd0, height});
    assign is_last  = (r_e == r_cnt - CW'(1));
    assign slot_ext = {3'd0, r_e};
    assign emit_ent = r_buf[r_e[BW-1:0]];

    always_comb begin
        unique case (r_state)
            S_TILE:  rd_addr = f_byte_addr(r_ent, 2'd1);
            S_ATTR:  rd_addr = f_byte_addr(r_ent, 2'd2);
            S_XPOS:  rd_addr = f_byte_addr(r_ent, 2'd3);
            default: rd_addr = f_byte_addr(r_n, 2'd0);
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_size16    = r_size16;
        n_thigh     = r_thigh;
        n_line      = r_line;
        n_n         = r_n;
        n_pend      = r_pend;
        n_pend_n    = r_pend_n;
        n_ent       = r_ent;
        n_row       = r_row;
        n_tile      = r_tile;
        n_attr      = r_attr;
        n_cnt       = r_cnt;
        n_e         = r_e;
        n_over      = r_over;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        buf_we      = 1'b0;
        buf_wdata   = '{pattern_addr: f_pattern(r_tile, r_attr, r_row, r_size16, r_thigh),
                        attributes: r_attr, x_position: rd_data,
                        is_sprite_zero: (r_ent == '0)};

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SIZE16:     n_size16 = i_cfg_data;
                CFG_TABLE_HIGH: n_thigh  = i_cfg_data;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.req_type == REQ_EVAL)) begin
                    n_line = i_in.target_line;
                    n_n    = '0;
                    n_pend = 1'b0;
                    n_cnt  = '0;
                    n_e    = '0;
                    n_over = 1'b0;
                    if (i_in.target_line >= 8'(VISIBLE_LINES)) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_pend && hit) begin
                    n_pend = 1'b0;
                    if (r_cnt == CW'(MAX_PER_LINE)) begin
                        n_over  = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        n_ent   = r_pend_n;
                        n_row   = diff[3:0];
                        n_state = S_TILE;
                    end
                end else if (r_n < NW'(SPRITE_ENTRIES)) begin
                    n_pend   = 1'b1;
                    n_pend_n = r_n;
                    n_n      = r_n + NW'(1);
                end else if (!r_pend) begin
                    n_state = S_EMIT;
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_TILE: begin
                n_state = S_ATTR;
            end
            S_ATTR: begin
                n_tile  = rd_data;
                n_state = S_XPOS;
            end
            S_XPOS: begin
                n_attr  = rd_data;
                n_state = S_STORE;
            end
            S_STORE: begin
                buf_we  = 1'b1;
                n_cnt   = r_cnt + CW'(1);
                n_n     = r_ent + NW'(1);
                n_state = S_SCAN;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_cnt == '0) begin
                        n_out      = '0;
                        n_out.last = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_out.slot           = slot_ext[2:0];
                        n_out.found          = 1'b1;
                        n_out.pattern_addr   = emit_ent.pattern_addr;
                        n_out.attributes     = emit_ent.attributes;
                        n_out.x_position     = emit_ent.x_position;
                        n_out.is_sprite_zero = emit_ent.is_sprite_zero;
                        n_out.overflow       = r_over;
                        n_out.last           = is_last;
                        n_e                  = r_e + CW'(1);
                        if (is_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size16    <= 1'b0;
            r_thigh     <= 1'b0;
            r_n         <= '0;
            r_pend      <= 1'b0;
            r_cnt       <= '0;
            r_e         <= '0;
            r_over      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size16    <= n_size16;
            r_thigh     <= n_thigh;
            r_n         <= n_n;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
            r_e         <= n_e;
            r_over      <= n_over;
            r_out_valid <= n_out_valid;
        end
        r_line   <= n_line;
        r_pend_n <= n_pend_n;
        r_ent    <= n_ent;
        r_row    <= n_row;
        r_tile   <= n_tile;
        r_attr   <= n_attr;
        r_out    <= n_out;
        if (buf_we) begin
            r_buf[r_cnt[BW-1:0]] <= buf_wdata;
        end
    end

endmodule

`default_nettype wire

// ----- src/sle_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "sprite_line_evaluator_assert.svh"

module sle_checker
    import sle_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire t_in_req    i_in,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire t_out_res   o_out,
    input wire logic       i_cfg_valid,
    input wire logic       o_cfg_ready,
    input wire logic [0:0] i_cfg_index,
    input wire logic       i_cfg_data
);

    logic empty_res;
    logic empty_clean;
    logic zero_res;
    logic zero_first;

    assign empty_res   = o_out_valid && !o_out.found;
    assign empty_clean = o_out.last && (o_out.slot == 3'd0) && (o_out.pattern_addr == 13'd0)
                         && (o_out.attributes == 8'd0) && (o_out.x_position == 8'd0)
                         && !o_out.is_sprite_zero && !o_out.overflow;
    assign zero_res    = o_out_valid && o_out.is_sprite_zero;
    assign zero_first  = o_out.found && (o_out.slot == 3'd0);

    `SLE_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped")

    `SLE_ASSERT_NXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out), "result changed")

    `SLE_ASSERT_IMP(a_empty_clean, empty_res, empty_clean, "empty result not clean")

    `SLE_ASSERT_IMP(a_zero_first, zero_res, zero_first, "sprite zero not in first slot")

    `SLE_ASSERT_IMP(a_busy_mid, o_out_valid && !o_out.last, !o_in_ready, "request taken mid line")

endmodule

bind sprite_line_evaluator sle_checker u_sle_checker (.*);

`default_nettype wire
